[sv/spbo_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package spbo_pkg;

	localparam int ENTRIES     = 64;
	localparam int IDX_W       = $clog2(ENTRIES);
	localparam int LEN_W       = IDX_W + 1;
	localparam int MAX_RESULTS = 63;
	localparam int CNT_W       = 6;
	localparam int QUEUE_DEPTH = 2;

	localparam int COORD_W = 16;
	localparam int SIZE_W  = 15;
	localparam int LO_W    = COORD_W + 1;
	localparam int HI_W    = COORD_W + 2;

	localparam int IN_DATA_W  = 112;
	localparam int OUT_DATA_W = 8;
	localparam int CFG_W      = 7;

	localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(ENTRIES);
	localparam logic [LEN_W-1:0] LEN_MIN = LEN_W'(2);

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic CFG_LIST_LENGTH  = 1'b0;
	localparam logic CFG_IGNORED_KIND = 1'b1;

	localparam logic [1:0] STATUS_ACTIVE = 2'd0;
	localparam logic [1:0] STATUS_DELETE = 2'd1;

	typedef struct packed {
		logic [1:0] kind;
		logic [1:0] status;
		logic       collidable;
		logic       present;
	} flags_t;

	// command from the front, left/top edges already summed
	typedef struct packed {
		logic                    op;
		logic [IDX_W-1:0]        idx;
		logic signed [LO_W-1:0]  left_x;
		logic signed [LO_W-1:0]  top_y;
		logic [SIZE_W-1:0]       width;
		logic [SIZE_W-1:0]       height;
		flags_t                  flags;
	} cmd_t;

	// one table entry as stored in the ram
	typedef struct packed {
		logic signed [LO_W-1:0] left_x;
		logic signed [HI_W-1:0] right_x;
		logic signed [LO_W-1:0] top_y;
		logic signed [HI_W-1:0] bottom_y;
		flags_t                 flags;
	} entry_t;

	typedef struct packed {
		logic             found;
		logic [IDX_W-1:0] partner;
		logic             handles;
		logic             last;
	} res_t;

endpackage
`default_nettype wire

[sv/sweep_prune_box_overlap_scan_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// sweep-and-prune broad phase over a 64-entry table of axis-aligned boxes. a beat with
// op 0 writes one entry (edges are formed from position, offset and size and stored
// with the flags); a beat with op 1 queries one entry and walks the later entries in
// table order, reporting each strict overlap as one output beat, the last flagged by
// tlast. a query that finds nothing still gives one beat with found 0. the table must
// be kept sorted by left edge by software: the walk stops at the first usable entry
// whose left edge reaches the queried right edge. a front stage decodes beats and sums
// the left/top edges into a two-deep command queue, so input beats keep flowing while
// the back end works, until the queue is full. a write is done in the back end's idle
// state; a query walks up to 63 later entries, one entry per cycle from the entry
// ram's single read port, holding whenever a result waits on a stalled output.
// configuration must be written only while idle; the block itself does not enforce
// this. a list_length above 64 acts as 64. no clearing pass is needed after reset.
module sweep_prune_box_overlap_scan_unit
	import spbo_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// config write port
	input  wire logic                  cfg_wr_en,
	input  wire logic                  cfg_index,
	input  wire logic [CFG_W-1:0]      cfg_data,
	// input stream
	input  wire logic                  s_axis_tvalid,
	output logic                       s_axis_tready,
	// entry_index[5:0], pos_x[21:6], pos_y[37:22], box_off_x[53:38], box_off_y[69:54],
	// box_width[84:70], box_height[99:85], present[100], collidable[101],
	// status[103:102], kind[105:104], zero fill
	input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,
	// op[0]
	input  wire logic                  s_axis_tuser,
	// result stream
	output logic                       m_axis_tvalid,
	input  wire logic                  m_axis_tready,
	// partner_index[5:0], query_handles[6], zero fill
	output logic [OUT_DATA_W-1:0]      m_axis_tdata,
	// found[0]
	output logic                       m_axis_tuser,
	output logic                       m_axis_tlast
);

	logic [LEN_W-1:0] list_length_q;
	logic [1:0]       ignored_kind_q;

	logic push_valid, push_ready, pop_valid, pop_ready;
	cmd_t push_cmd, pop_cmd;
	res_t res;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_length_q  <= '0;
			ignored_kind_q <= '0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_LIST_LENGTH:  list_length_q  <= cfg_data[LEN_W-1:0];
				CFG_IGNORED_KIND: ignored_kind_q <= cfg_data[1:0];
			endcase
		end
	end

	// decode and edge sums
	spbo_front u_front (
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_data   (s_axis_tdata),
		.in_op     (s_axis_tuser),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd)
	);

	// decouples beat intake from the table walk
	spbo_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_cmd  (push_cmd),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_cmd   (pop_cmd)
	);

	// table storage, scan and result register
	spbo_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_cmd     (pop_cmd),
		.list_length (list_length_q),
		.ignored_kind(ignored_kind_q),
		.out_valid   (m_axis_tvalid),
		.out_ready   (m_axis_tready),
		.out_res     (res)
	);

	assign m_axis_tdata = {{(OUT_DATA_W - IDX_W - 1){1'b0}}, res.handles, res.partner};
	assign m_axis_tuser = res.found;
	assign m_axis_tlast = res.last;

endmodule
`default_nettype wire

[sv/spbo_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
module spbo_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[sv/spbo_front.sv]
`timescale 1ns / 1ps
`default_nettype none
module spbo_front
	import spbo_pkg::*;
(
	input  wire logic                 in_valid,
	output logic                      in_ready,
	input  wire logic [IN_DATA_W-1:0] in_data,
	input  wire logic                 in_op,
	output logic                      push_valid,
	input  wire logic                 push_ready,
	output cmd_t                      push_cmd
);

	logic [COORD_W-1:0] pos_x, pos_y, off_x, off_y;

	assign pos_x = in_data[21:6];
	assign pos_y = in_data[37:22];
	assign off_x = in_data[53:38];
	assign off_y = in_data[69:54];

	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	// left/top edges: exact 17-bit signed sums of position and offset
	always_comb begin
		push_cmd                  = '0;
		push_cmd.op               = in_op;
		push_cmd.idx              = in_data[5:0];
		push_cmd.left_x           = {pos_x[COORD_W-1], pos_x} + {off_x[COORD_W-1], off_x};
		push_cmd.top_y            = {pos_y[COORD_W-1], pos_y} + {off_y[COORD_W-1], off_y};
		push_cmd.width            = in_data[84:70];
		push_cmd.height           = in_data[99:85];
		push_cmd.flags.present    = in_data[100];
		push_cmd.flags.collidable = in_data[101];
		push_cmd.flags.status     = in_data[103:102];
		push_cmd.flags.kind       = in_data[105:104];
	end

endmodule
`default_nettype wire

[sv/spbo_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
module spbo_queue
	import spbo_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push_valid,
	output logic      push_ready,
	input  cmd_t      push_cmd,
	output logic      pop_valid,
	input  wire logic pop_ready,
	output cmd_t      pop_cmd
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_QW = PTR_W + 1;

	cmd_t              slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [CNT_QW-1:0] fill_q;
	logic              do_push, do_pop;

	assign push_ready = (fill_q != CNT_QW'(QUEUE_DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

[sv/spbo_back.sv]
`timescale 1ns / 1ps
`default_nettype none
module spbo_back
	import spbo_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             pop_valid,
	output logic                  pop_ready,
	input  cmd_t                  pop_cmd,
	input  wire logic [LEN_W-1:0] list_length,
	input  wire logic [1:0]       ignored_kind,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output res_t                  out_res
);

	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_LOADQ  = 2'd1;
	localparam logic [1:0] ST_SCAN   = 2'd2;
	localparam logic [1:0] ST_FINISH = 2'd3;

	logic [1:0]   st_q, st_d;
	logic [ENTRIES-1:0] vld_q;
	logic         rd_vld_s1;

	logic         ram_we;
	entry_t       wr_entry, rd_entry;
	logic [IDX_W-1:0] rd_addr;
	flags_t       rd_flags;

	logic [IDX_W-1:0] q_idx_q, q_idx_d;
	logic [IDX_W-1:0] j_q, j_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic         pend_valid_q, pend_valid_d;
	res_t         pend_q, pend_d;
	logic         out_valid_q, out_load, out_free;
	res_t         out_q, out_d;
	logic         latch_q;

	logic signed [HI_W-1:0] ql_q, qr_q, qt_q, qb_q;
	logic [1:0]   qkind_q;
	logic signed [HI_W-1:0] jl, jr, jt, jb;
	logic [LEN_W-1:0] len, j_first, j_next;
	logic         q_ok, scan_use, scan_brk, scan_ovl, scan_ign, scan_hit;

	spbo_ram #(
		.WIDTH($bits(entry_t)),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(pop_cmd.idx),
		.wdata(wr_entry),
		.raddr(rd_addr),
		.rdata(rd_entry)
	);

	always_comb begin
		wr_entry          = '0;
		wr_entry.left_x   = pop_cmd.left_x;
		wr_entry.right_x  = {pop_cmd.left_x[LO_W-1], pop_cmd.left_x}
		                  + {{(HI_W-SIZE_W){1'b0}}, pop_cmd.width};
		wr_entry.top_y    = pop_cmd.top_y;
		wr_entry.bottom_y = {pop_cmd.top_y[LO_W-1], pop_cmd.top_y}
		                  + {{(HI_W-SIZE_W){1'b0}}, pop_cmd.height};
		wr_entry.flags    = pop_cmd.flags;
	end

	// never written entries read as empty
	assign rd_flags = rd_vld_s1 ? rd_entry.flags : '0;
	assign len      = (list_length > LEN_MAX) ? LEN_MAX : list_length;
	assign j_first  = {1'b0, q_idx_q} + 1'b1;
	assign j_next   = {1'b0, j_q} + 1'b1;
	assign out_free = !out_valid_q || out_ready;

	assign jl = {rd_entry.left_x[LO_W-1], rd_entry.left_x};
	assign jr = rd_entry.right_x;
	assign jt = {rd_entry.top_y[LO_W-1], rd_entry.top_y};
	assign jb = rd_entry.bottom_y;

	assign q_ok     = rd_flags.present && (rd_flags.status != STATUS_DELETE);
	assign scan_use = rd_flags.present && rd_flags.collidable
	               && (rd_flags.status == STATUS_ACTIVE);
	assign scan_brk = (qr_q <= jl);
	assign scan_ovl = (ql_q < jr) && (jl < qr_q) && (qt_q < jb) && (jt < qb_q);
	assign scan_ign = (qkind_q == rd_flags.kind) && (qkind_q == ignored_kind);
	assign scan_hit = scan_use && !scan_brk && scan_ovl && !scan_ign;

	always_comb begin
		st_d         = st_q;
		q_idx_d      = q_idx_q;
		j_d          = j_q;
		cnt_d        = cnt_q;
		pend_valid_d = pend_valid_q;
		pend_d       = pend_q;
		out_load     = 1'b0;
		out_d        = out_q;
		ram_we       = 1'b0;
		rd_addr      = j_q;
		pop_ready    = 1'b0;
		latch_q      = 1'b0;
		unique case (st_q)
			ST_IDLE: begin
				pop_ready = 1'b1;
				rd_addr   = pop_cmd.idx;
				if (pop_valid) begin
					if (pop_cmd.op == OP_WRITE) begin
						ram_we = 1'b1;
					end else begin
						q_idx_d      = pop_cmd.idx;
						pend_valid_d = 1'b0;
						cnt_d        = '0;
						if ((len >= LEN_MIN) && ({1'b0, pop_cmd.idx} < len)) begin
							st_d = ST_LOADQ;
						end else begin
							st_d = ST_FINISH;
						end
					end
				end
			end
			ST_LOADQ: begin
				// queried entry is on the read port, start the walk behind it
				rd_addr = j_first[IDX_W-1:0];
				latch_q = 1'b1;
				if (!q_ok || (j_first >= len)) begin
					st_d = ST_FINISH;
				end else begin
					j_d  = j_first[IDX_W-1:0];
					st_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_addr = j_next[IDX_W-1:0];
				if (scan_use && scan_brk) begin
					st_d = ST_FINISH;
				end else if (scan_hit) begin
					if (pend_valid_q && !out_free) begin
						// hold: reread the same entry
						rd_addr = j_q;
					end else begin
						if (pend_valid_q) begin
							out_load = 1'b1;
							out_d    = pend_q;
						end
						pend_d.found   = 1'b1;
						pend_d.partner = j_q;
						pend_d.handles = (qkind_q > rd_flags.kind);
						pend_d.last    = 1'b0;
						pend_valid_d   = 1'b1;
						cnt_d          = cnt_q + 1'b1;
						if (cnt_q == CNT_W'(MAX_RESULTS - 1)) begin
							st_d = ST_FINISH;
						end else if (j_next >= len) begin
							st_d = ST_FINISH;
						end else begin
							j_d = j_next[IDX_W-1:0];
						end
					end
				end else if (j_next >= len) begin
					st_d = ST_FINISH;
				end else begin
					j_d = j_next[IDX_W-1:0];
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_load = 1'b1;
					if (pend_valid_q) begin
						out_d      = pend_q;
						out_d.last = 1'b1;
					end else begin
						out_d      = '0;
						out_d.last = 1'b1;
					end
					pend_valid_d = 1'b0;
					st_d         = ST_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk) begin
		pend_q  <= pend_d;
		j_q     <= j_d;
		q_idx_q <= q_idx_d;
		cnt_q   <= cnt_d;
		if (out_load) begin
			out_q <= out_d;
		end
		if (latch_q) begin
			ql_q    <= {rd_entry.left_x[LO_W-1], rd_entry.left_x};
			qr_q    <= rd_entry.right_x;
			qt_q    <= {rd_entry.top_y[LO_W-1], rd_entry.top_y};
			qb_q    <= rd_entry.bottom_y;
			qkind_q <= rd_flags.kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q         <= ST_IDLE;
			vld_q        <= '0;
			rd_vld_s1    <= 1'b0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			st_q         <= st_d;
			rd_vld_s1    <= vld_q[rd_addr];
			pend_valid_q <= pend_valid_d;
			if (ram_we) begin
				vld_q[pop_cmd.idx] <= 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_res   = out_q;

endmodule
`default_nettype wire

[test/tb_sweep_prune_box_overlap_scan_unit.sv]
`timescale 1ns / 1ps
module tb_sweep_prune_box_overlap_scan_unit;
	import spbo_pkg::*;

	// status codes the package leaves unnamed
	localparam logic [1:0] STATUS_PENDING = 2'd2;
	localparam logic [1:0] STATUS_OTHER   = 2'd3;

	localparam logic signed [COORD_W-1:0] COORD_MIN = 16'sh8000;
	localparam logic signed [COORD_W-1:0] COORD_MAX = 16'sh7FFF;
	localparam logic signed [COORD_W-1:0] COORD_NEG1 = 16'shFFFF;
	localparam logic [SIZE_W-1:0] SIZE_MAX = 15'h7FFF;

	// cycles to let a queued write or query finish when no result marks its end
	localparam int SETTLE_CYCLES  = 80;
	localparam int HOLD_CYCLES    = 500;
	localparam int WATCHDOG_LIMIT = 3000;

	// one input beat before packing
	typedef struct {
		logic                      op;
		logic [IDX_W-1:0]          idx;
		logic signed [COORD_W-1:0] px, py, ox, oy;
		logic [SIZE_W-1:0]         w, h;
		logic                      present, collid;
		logic [1:0]                status, kind;
	} box_cmd_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic cfg_index = 1'b0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = 1'b0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic m_axis_tuser;
	logic m_axis_tlast;

	sweep_prune_box_overlap_scan_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// shadow copy of the box table and registers
	logic signed [LO_W-1:0] box_left   [ENTRIES];
	logic signed [HI_W-1:0] box_right  [ENTRIES];
	logic signed [LO_W-1:0] box_top    [ENTRIES];
	logic signed [HI_W-1:0] box_bottom [ENTRIES];
	flags_t                 box_flags  [ENTRIES];
	logic [LEN_W-1:0]       cfg_len = '0;
	logic [1:0]             cfg_ignored = '0;

	res_t expected_pairs[$];
	int   mismatch_count = 0;

	// pacing knobs, percent of cycles
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_req = 1'b0;
	int hold_left = 0;
	int quiet_cycles = 0;

	// scene layout used by the sorted-table generator
	int scene_left [ENTRIES];
	int scene_ybase = 0;
	int scene_wmax = 600;

	function automatic logic [IN_DATA_W-1:0] pack_beat(input box_cmd_t c);
		return {6'b0, c.kind, c.status, c.collid, c.present, c.h, c.w,
			c.oy, c.ox, c.py, c.px, c.idx};
	endfunction

	// applies a write to the shadow table, or walks the later entries for a query
	function automatic void predict_beat(input box_cmd_t c);
		logic signed [LO_W-1:0] lo_x, lo_y;
		logic signed [HI_W-1:0] wide;
		logic [LEN_W-1:0] eff_len;
		int qi;
		int n;
		int hits[$];
		logic [1:0] qk, pk;
		logic hq;
		res_t r;
		flags_t pf;

		qi = c.idx;
		if (c.op == OP_WRITE) begin
			lo_x = c.px + c.ox;
			lo_y = c.py + c.oy;
			box_left[qi] = lo_x;
			box_top[qi] = lo_y;
			wide = lo_x;
			box_right[qi] = wide + $signed({3'b000, c.w});
			wide = lo_y;
			box_bottom[qi] = wide + $signed({3'b000, c.h});
			box_flags[qi] = '{kind: c.kind, status: c.status,
				collidable: c.collid, present: c.present};
			return;
		end

		eff_len = (cfg_len > LEN_MAX) ? LEN_MAX : cfg_len;
		n = eff_len;
		qk = box_flags[qi].kind;
		// queried entry must be present and not marked for deletion
		if (n >= 2 && qi < n && box_flags[qi].present &&
				box_flags[qi].status != STATUS_DELETE) begin
			for (int j = qi + 1; j < n; j++) begin
				pf = box_flags[j];
				if (!pf.present || !pf.collidable || pf.status != STATUS_ACTIVE)
					continue;
				// sweep stop: partner starts at or past our right edge
				if (box_right[qi] <= box_left[j])
					break;
				if (!(box_left[qi] < box_right[j] && box_left[j] < box_right[qi] &&
						box_top[qi] < box_bottom[j] && box_top[j] < box_bottom[qi]))
					continue;
				pk = pf.kind;
				if (qk == pk && qk == cfg_ignored)
					continue;
				hits.push_back(j);
				if (hits.size() >= MAX_RESULTS)
					break;
			end
		end

		if (hits.size() == 0) begin
			r = '{found: 1'b0, partner: '0, handles: 1'b0, last: 1'b1};
			expected_pairs.push_back(r);
		end else begin
			foreach (hits[k]) begin
				pk = box_flags[hits[k]].kind;
				hq = (qk > pk);
				r = '{found: 1'b1, partner: IDX_W'(hits[k]), handles: hq,
					last: (k == hits.size() - 1)};
				expected_pairs.push_back(r);
			end
		end
	endfunction

	// offers one beat, waits for the handshake, then maybe goes idle
	task automatic send_beat(input box_cmd_t c);
		s_axis_tdata <= pack_beat(c);
		s_axis_tuser <= c.op;
		s_axis_tvalid <= 1'b1;
		do @(posedge clk); while (!s_axis_tready);
		predict_beat(c);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
	endtask

	task automatic send_write(input logic [IDX_W-1:0] idx,
			input logic signed [COORD_W-1:0] px, py, ox, oy,
			input logic [SIZE_W-1:0] w, h,
			input logic present, collid,
			input logic [1:0] status, kind);
		box_cmd_t c;
		c = '{op: OP_WRITE, idx: idx, px: px, py: py, ox: ox, oy: oy, w: w, h: h,
			present: present, collid: collid, status: status, kind: kind};
		send_beat(c);
	endtask

	task automatic send_query(input logic [IDX_W-1:0] idx);
		box_cmd_t c;
		c = '{op: OP_QUERY, idx: idx, px: '0, py: '0, ox: '0, oy: '0, w: '0, h: '0,
			present: 1'b0, collid: 1'b0, status: '0, kind: '0};
		send_beat(c);
	endtask

	// sender pauses until every expected beat is back and the back end is idle
	task automatic wait_for_quiet();
		s_axis_tvalid <= 1'b0;
		while (expected_pairs.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input int len_v, input int ign_v);
		wait_for_quiet();
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_LIST_LENGTH;
		cfg_data <= CFG_W'(len_v);
		@(posedge clk);
		cfg_index <= CFG_IGNORED_KIND;
		cfg_data <= CFG_W'(ign_v);
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		@(posedge clk);
		cfg_len = LEN_W'(len_v);
		cfg_ignored = 2'(ign_v);
	endtask

	// splits an edge into position plus offset, both in 16-bit range
	task automatic split_coord(input int target, output logic signed [COORD_W-1:0] p, o);
		int lo;
		int hi;
		int off;
		lo = target - 32767;
		if (lo < -32768)
			lo = -32768;
		hi = target + 32768;
		if (hi > 32767)
			hi = 32767;
		off = lo + int'($urandom_range(0, hi - lo));
		o = COORD_W'(off);
		p = COORD_W'(target - off);
	endtask

	task automatic write_scene_entry(input int j, input int left);
		logic signed [COORD_W-1:0] px, ox, py, oy;
		logic [SIZE_W-1:0] w, h;
		logic [1:0] st;
		int top;
		split_coord(left, px, ox);
		top = scene_ybase + int'($urandom_range(0, 400));
		split_coord(top, py, oy);
		w = ($urandom_range(15) == 0) ? SIZE_W'($urandom)
			: SIZE_W'($urandom_range(0, scene_wmax));
		h = ($urandom_range(15) == 0) ? SIZE_W'($urandom) : SIZE_W'($urandom_range(0, 400));
		st = ($urandom_range(4) == 0) ? 2'($urandom_range(1, 3)) : STATUS_ACTIVE;
		send_write(IDX_W'(j), px, py, ox, oy, w, h, $urandom_range(9) != 0,
			$urandom_range(6) != 0, st, 2'($urandom));
	endtask

	// writes entries 0..n-1 with nondecreasing left edges
	task automatic build_scene(input int n, input int step_max);
		int left;
		left = int'($urandom_range(0, 110000)) - 60000;
		scene_ybase = int'($urandom_range(0, 120000)) - 60000;
		for (int j = 0; j < n; j++) begin
			scene_left[j] = left;
			write_scene_entry(j, left);
			left += int'($urandom_range(0, step_max));
		end
	endtask

	// pair rules on a two-entry list: kinds, flags, statuses, strict edges
	task automatic test_pair_cases();
		set_config(2, 0);
		// smallest edges, largest size
		send_write(0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
			1, 1, STATUS_ACTIVE, 2);
		send_write(1, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
			1, 1, STATUS_ACTIVE, 1);
		send_query(0);
		send_query(1);
		send_write(1, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
			1, 1, STATUS_ACTIVE, 3);
		send_query(0);
		// partner not collidable, not active, or empty
		send_write(1, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
			1, 0, STATUS_ACTIVE, 3);
		send_query(0);
		send_write(1, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
			1, 1, STATUS_DELETE, 3);
		send_query(0);
		send_write(1, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
			1, 1, STATUS_OTHER, 3);
		send_query(0);
		send_write(1, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
			0, 1, STATUS_ACTIVE, 3);
		send_query(0);
		// queried entry's own collidable flag does not matter, pending statuses pass
		send_write(1, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
			1, 1, STATUS_ACTIVE, 2);
		send_write(0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
			1, 0, STATUS_PENDING, 2);
		send_query(0);
		send_write(0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
			1, 1, STATUS_OTHER, 2);
		send_query(0);
		send_write(0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
			1, 1, STATUS_DELETE, 2);
		send_query(0);
		send_write(0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
			0, 1, STATUS_ACTIVE, 2);
		send_query(0);
		// same kind as the ignored one is dropped, other ignored kind lets it through
		set_config(2, 2);
		send_write(0, COORD_MIN, COORD_MIN, COORD_MIN, COORD_MIN, SIZE_MAX, SIZE_MAX,
			1, 1, STATUS_ACTIVE, 2);
		send_query(0);
		set_config(2, 3);
		send_query(0);
		// partner left edge exactly on our right edge stops the sweep
		send_write(1, COORD_MIN, COORD_MIN, COORD_NEG1, COORD_MIN, 15'd100, 15'd100,
			1, 1, STATUS_ACTIVE, 0);
		send_query(0);
		// touching in y only is not a strict overlap
		send_write(1, COORD_MIN, COORD_MIN, COORD_MIN, COORD_NEG1, 15'd100, 15'd100,
			1, 1, STATUS_ACTIVE, 0);
		send_query(0);
		// largest edges
		send_write(0, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, SIZE_MAX, SIZE_MAX,
			1, 1, STATUS_ACTIVE, 2);
		send_write(1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 15'd0, SIZE_MAX,
			1, 1, STATUS_ACTIVE, 0);
		send_query(0);
		send_write(1, COORD_MAX, COORD_MAX, COORD_MAX, COORD_MAX, 15'd1, SIZE_MAX,
			1, 1, STATUS_ACTIVE, 0);
		send_query(0);
	endtask

	// list lengths below two and queries at or past the list end find nothing
	task automatic test_short_lists();
		set_config(0, 0);
		send_query(0);
		set_config(1, 0);
		send_query(0);
		set_config(2, 0);
		send_query(5);
		send_query(63);
	endtask

	// all entries overlap: a full 63-entry walk, and lengths above 64
	task automatic test_full_scan();
		set_config(ENTRIES, 1);
		for (int j = 0; j < ENTRIES; j++)
			send_write(IDX_W'(j), '0, '0, '0, '0, SIZE_MAX, SIZE_MAX, 1, 1,
				STATUS_ACTIVE, 2'($urandom));
		send_query(0);
		set_config(127, 0);
		send_query(0);
		send_query(63);
		set_config(65, 3);
		send_query(1);
		send_query(62);
	endtask

	// receiver holds off long enough for the input side to back up,
	// queries walk the fully overlapping table left by the full scan
	task automatic test_holdoff();
		send_idle_pct = 0;
		recv_stall_pct = 0;
		set_config(ENTRIES, 0);
		hold_req = 1'b1;
		for (int k = 0; k < 12; k++)
			send_query(IDX_W'(k));
		wait_for_quiet();
	endtask

	task automatic run_phase(input int idle, input int stall, input int len_v,
			input int ign_v, input int count);
		int n;
		int r;
		int j;
		set_config(len_v, ign_v);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		n = (len_v > ENTRIES) ? ENTRIES : len_v;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(99);
			if (r < 78) begin
				if ($urandom_range(9) == 0)
					send_query(IDX_W'($urandom));
				else
					send_query(IDX_W'($urandom_range(0, n - 1)));
			end else if (r < 90) begin
				// rewrite keeping the left edge, so the table stays sorted
				j = $urandom_range(0, n - 1);
				write_scene_entry(j, scene_left[j]);
			end else begin
				// raw write, may leave the table unsorted
				send_write(IDX_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
					COORD_W'($urandom), COORD_W'($urandom), SIZE_W'($urandom),
					SIZE_W'($urandom), 1'($urandom), 1'($urandom), 2'($urandom),
					2'($urandom));
			end
		end
	endtask

	// one sorted scene over the whole table, shared by all pacing phases
	task automatic test_random_phases();
		build_scene(ENTRIES, 80);
		run_phase(0, 0, ENTRIES, $urandom_range(0, 3), 35);
		run_phase(67, 0, $urandom_range(3, 63), $urandom_range(0, 3), 35);
		run_phase(0, 67, 127, $urandom_range(0, 3), 35);
		run_phase(10, 10, $urandom_range(2, 64), $urandom_range(0, 3), 35);
		send_idle_pct = 0;
		recv_stall_pct = 0;
	endtask

	// receiver: random stalls, or a counted hold-off when requested
	always @(posedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left = hold_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// result beats against the oldest prediction
	always @(posedge clk) begin
		res_t got;
		res_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			got = {m_axis_tuser, m_axis_tdata[IDX_W-1:0], m_axis_tdata[IDX_W], m_axis_tlast};
			if (expected_pairs.size() == 0) begin
				mismatch_count++;
				$display("%0t unexpected beat: found %0d partner %0d handles %0d last %0d",
					$time, got.found, got.partner, got.handles, got.last);
			end else begin
				want = expected_pairs.pop_front();
				if (got !== want) begin
					mismatch_count++;
					$display({"%0t mismatch: expected found %0d partner %0d handles %0d ",
						"last %0d, actual found %0d partner %0d handles %0d last %0d"},
						$time, want.found, want.partner, want.handles, want.last,
						got.found, got.partner, got.handles, got.last);
				end
			end
		end
	end

	// watchdog on cycles with no beat on either side
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t watchdog: no beat for %0d cycles", $time, quiet_cycles);
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		for (int j = 0; j < ENTRIES; j++)
			box_flags[j] = '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_pair_cases();
		test_short_lists();
		test_full_scan();
		test_holdoff();
		test_random_phases();
		wait_for_quiet();
		if (mismatch_count == 0 && expected_pairs.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

[sweep_prune_box_overlap_scan_unit.f]
sv/spbo_pkg.sv
sv/spbo_ram.sv
sv/spbo_front.sv
sv/spbo_queue.sv
sv/spbo_back.sv
sv/sweep_prune_box_overlap_scan_unit.sv
test/tb_sweep_prune_box_overlap_scan_unit.sv
